// File: sv/assert_macros.svh
// Assertion macros for the RTL of the first-fit allocator.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: sv/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// Used by the engine, the top level and the testbench; depends on nothing.
package ffha_pkg;

	localparam int ARENA_BYTES_DEF  = 16384;
	localparam int HEADER_BYTES_DEF = 24;
	localparam int MAX_SEGMENTS_DEF = 256;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFIT  = 2'd1;
	localparam logic [1:0] ST_BADPTR = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	// Command codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic        command;
		logic [14:0] req_bytes;
		logic [13:0] release_offset;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [13:0] payload_offset;
		logic        was_split;
	} out_t;

endpackage

// File: sv/ffha_seg_mem.sv
// Segment table storage: one write port, one read port, registered read data.
// Depends on nothing beyond its parameters.
module ffha_seg_mem #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 256,
	localparam int IW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [IW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: sv/ffha_engine.sv
// Sequencer of the allocator: scans, splits, merges and compacts the table.
// Depends on ffha_pkg; drives the ports of ffha_seg_mem.
module ffha_engine #(
	parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
	parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF,
	localparam int AW  = $clog2(ARENA_BYTES + 1),
	localparam int IW  = $clog2(MAX_SEGMENTS),
	localparam int CNW = $clog2(MAX_SEGMENTS + 1),
	localparam int EW  = 2 * AW + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ffha_pkg::in_t      cmd_in,
	output logic               idle,
	output logic               res_valid,
	output ffha_pkg::out_t     res,
	input  logic               res_ack,
	output logic               mem_we,
	output logic [IW-1:0]      mem_waddr,
	output logic [EW-1:0]      mem_wdata,
	output logic [IW-1:0]      mem_raddr,
	input  logic [EW-1:0]      mem_rdata
);

	localparam int CW = ((AW > 15) ? AW : 15) + 2;
	localparam logic [CW-1:0] HDR = CW'(HEADER_BYTES);
	localparam logic [AW-1:0] INIT_SIZE = AW'(ARENA_BYTES - HEADER_BYTES);
	localparam logic [CNW-1:0] CNT_MAX = CNW'(MAX_SEGMENTS);

	localparam logic [3:0] S_INIT     = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_SCAN     = 4'd2;
	localparam logic [3:0] S_SPLIT_SH = 4'd3;
	localparam logic [3:0] S_SPLIT_WR = 4'd4;
	localparam logic [3:0] S_F_RDP    = 4'd5;
	localparam logic [3:0] S_F_RDN    = 4'd6;
	localparam logic [3:0] S_F_MRG    = 4'd7;
	localparam logic [3:0] S_COMPACT  = 4'd8;
	localparam logic [3:0] S_RESULT   = 4'd9;

	logic [3:0]     state_q;
	ffha_pkg::in_t  cmd_q;
	logic [CNW-1:0] count_q;
	logic [CNW-1:0] rd_idx_q;
	logic           chk_vld_s1;
	logic [IW-1:0]  chk_idx_s1;
	logic [IW-1:0]  f_q;
	logic [AW-1:0]  cur_start_q, cur_size_q;
	logic [AW-1:0]  prev_start_q, prev_size_q;
	logic           prev_busy_q;
	logic [CNW-1:0] sh_rd_q;
	logic           wr_vld_s1;
	logic [IW-1:0]  wr_addr_s1;
	logic [1:0]     mrg_r_q;
	ffha_pkg::out_t res_q;

	logic [AW-1:0]  rd_start, rd_size;
	logic           rd_busy;
	logic [CW-1:0]  size_x, req_x, start_x;
	logic           alloc_hit, free_hit, hit, scan_end;
	logic           is_exact, is_split;
	logic [13:0]    grant_off;
	logic           mp, mn;
	logic [1:0]     r_c;
	logic [IW-1:0]  lo_c;
	logic [AW-1:0]  m_start;
	logic [CW-1:0]  m_size;
	logic [CW-1:0]  new_start, new_size;
	logic [CNW-1:0] sh_dst;
	logic           sh_issue, cp_issue;

	// Field decode of the read data and match checks.
	always_comb begin
		rd_start  = mem_rdata[AW-1:0];
		rd_size   = mem_rdata[2*AW-1:AW];
		rd_busy   = mem_rdata[EW-1];
		size_x    = CW'(rd_size);
		req_x     = CW'(cmd_q.req_bytes);
		start_x   = CW'(rd_start);
		alloc_hit = !rd_busy && (size_x >= req_x);
		free_hit  = (start_x + HDR) == CW'(cmd_q.release_offset);
		hit       = chk_vld_s1 && ((cmd_q.command == ffha_pkg::CMD_FREE) ? free_hit : alloc_hit);
		scan_end  = !chk_vld_s1 && (rd_idx_q != '0);
		is_exact  = size_x == req_x;
		is_split  = size_x > (req_x + HDR);
		grant_off = 14'(start_x + HDR);
	end

	// Split remainder and merge results.
	always_comb begin
		new_start = CW'(cur_start_q) + HDR + CW'(cmd_q.req_bytes);
		new_size  = CW'(cur_size_q) - CW'(cmd_q.req_bytes) - HDR;
		mp        = (f_q != '0) && !prev_busy_q;
		mn        = ((CNW'(f_q) + CNW'(1)) < count_q) && !rd_busy;
		r_c       = {1'b0, mp} + {1'b0, mn};
		lo_c      = mp ? (f_q - IW'(1)) : f_q;
		m_start   = mp ? prev_start_q : cur_start_q;
		m_size    = CW'(cur_size_q)
			+ (mp ? (CW'(prev_size_q) + HDR) : '0)
			+ (mn ? (CW'(rd_size) + HDR) : '0);
		sh_dst    = sh_rd_q - CNW'(mrg_r_q);
		sh_issue  = sh_rd_q > CNW'(f_q);
		cp_issue  = sh_rd_q < count_q;
	end

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_addr_s1;
		mem_wdata = mem_rdata;
		mem_raddr = rd_idx_q[IW-1:0];
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = {1'b0, INIT_SIZE, AW'(0)};
			end
			S_SCAN: begin
				mem_waddr = chk_idx_s1;
				mem_wdata = {1'b1, AW'(cmd_q.req_bytes), rd_start};
				mem_we    = hit && (cmd_q.command == ffha_pkg::CMD_ALLOC)
					&& (is_exact || (is_split && (count_q != CNT_MAX)));
			end
			S_SPLIT_SH, S_COMPACT: begin
				mem_raddr = sh_rd_q[IW-1:0];
				mem_we    = wr_vld_s1;
			end
			S_SPLIT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = f_q + IW'(1);
				mem_wdata = {1'b0, AW'(new_size), AW'(new_start)};
			end
			S_F_RDP: begin
				mem_raddr = f_q - IW'(1);
			end
			S_F_RDN: begin
				mem_raddr = f_q + IW'(1);
			end
			S_F_MRG: begin
				mem_we    = 1'b1;
				mem_waddr = lo_c;
				mem_wdata = {1'b0, AW'(m_size), m_start};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Control state machine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			count_q    <= CNW'(1);
			chk_vld_s1 <= 1'b0;
			wr_vld_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						state_q    <= S_SCAN;
						cmd_q      <= cmd_in;
						rd_idx_q   <= '0;
						chk_vld_s1 <= 1'b0;
					end
				end
				S_SCAN: begin
					chk_vld_s1 <= !hit && (rd_idx_q < count_q);
					chk_idx_s1 <= rd_idx_q[IW-1:0];
					if (rd_idx_q < count_q) begin
						rd_idx_q <= rd_idx_q + CNW'(1);
					end
					if (hit) begin
						f_q         <= chk_idx_s1;
						cur_start_q <= rd_start;
						cur_size_q  <= rd_size;
						if (cmd_q.command == ffha_pkg::CMD_FREE) begin
							if (!rd_busy) begin
								res_q   <= '{status: ffha_pkg::ST_BADPTR, payload_offset: '0,
									was_split: 1'b0};
								state_q <= S_RESULT;
							end else begin
								state_q <= S_F_RDP;
							end
						end else if (is_exact) begin
							res_q   <= '{status: ffha_pkg::ST_OK, payload_offset: grant_off,
								was_split: 1'b0};
							state_q <= S_RESULT;
						end else if (is_split) begin
							if (count_q == CNT_MAX) begin
								res_q   <= '{status: ffha_pkg::ST_FULL, payload_offset: '0,
									was_split: 1'b0};
								state_q <= S_RESULT;
							end else begin
								res_q     <= '{status: ffha_pkg::ST_OK, payload_offset: grant_off,
									was_split: 1'b1};
								sh_rd_q   <= count_q - CNW'(1);
								wr_vld_s1 <= 1'b0;
								state_q   <= S_SPLIT_SH;
							end
						end else begin
							res_q   <= '{status: ffha_pkg::ST_NOFIT, payload_offset: '0,
								was_split: 1'b0};
							state_q <= S_RESULT;
						end
					end else if (scan_end) begin
						res_q   <= '{status: (cmd_q.command == ffha_pkg::CMD_FREE)
							? ffha_pkg::ST_BADPTR : ffha_pkg::ST_NOFIT,
							payload_offset: '0, was_split: 1'b0};
						state_q <= S_RESULT;
					end
				end
				S_SPLIT_SH: begin
					// Move entries up by one, highest first.
					wr_vld_s1  <= sh_issue;
					wr_addr_s1 <= sh_rd_q[IW-1:0] + IW'(1);
					if (sh_issue) begin
						sh_rd_q <= sh_rd_q - CNW'(1);
					end else if (!wr_vld_s1) begin
						state_q <= S_SPLIT_WR;
					end
				end
				S_SPLIT_WR: begin
					count_q <= count_q + CNW'(1);
					state_q <= S_RESULT;
				end
				S_F_RDP: begin
					state_q <= S_F_RDN;
				end
				S_F_RDN: begin
					prev_start_q <= rd_start;
					prev_size_q  <= rd_size;
					prev_busy_q  <= rd_busy;
					state_q      <= S_F_MRG;
				end
				S_F_MRG: begin
					res_q     <= '{status: ffha_pkg::ST_OK, payload_offset: '0, was_split: 1'b0};
					mrg_r_q   <= r_c;
					sh_rd_q   <= CNW'(lo_c) + CNW'(1) + CNW'(r_c);
					wr_vld_s1 <= 1'b0;
					state_q   <= (r_c == 2'd0) ? S_RESULT : S_COMPACT;
				end
				S_COMPACT: begin
					// Close the gap left by merged entries, lowest first.
					wr_vld_s1  <= cp_issue;
					wr_addr_s1 <= sh_dst[IW-1:0];
					if (cp_issue) begin
						sh_rd_q <= sh_rd_q + CNW'(1);
					end else if (!wr_vld_s1) begin
						count_q <= count_q - CNW'(mrg_r_q);
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (res_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle      = state_q == S_IDLE;
	assign res_valid = state_q == S_RESULT;
	assign res       = res_q;

endmodule

// File: sv/first_fit_heap_allocator.sv
// First-fit heap allocator with split and coalesce: top level.
// Depends on ffha_pkg, ffha_engine, ffha_seg_mem and assert_macros.svh.
//
// Requests arrive on in_valid/in_ready with in_data (command, req_bytes,
// release_offset); one result per request leaves on out_valid/out_ready
// with out_data (status, payload_offset, was_split).
// The block works on one transaction at a time. An allocate scans the
// segment table from entry 0, one entry per cycle out of the table memory;
// a split then moves every entry above the chosen one up by one and writes
// the remainder entry. A free scans the same way, then reads both neighbors
// and closes the gap left by merged entries, one entry per cycle. The worst
// case is set by the single read port of the table memory.
// After reset the block writes the initial free segment in S_INIT and
// then raises in_ready. A finished result sits in the output register;
// while the receiver stalls, the next request may still be accepted and
// processed, and its result waits until the output register frees up.
`include "assert_macros.svh"
module first_fit_heap_allocator #(
	parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
	parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ffha_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ffha_pkg::out_t out_data
);

	localparam int AW = $clog2(ARENA_BYTES + 1);
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int EW = 2 * AW + 1;

	logic           eng_idle, res_valid, res_ack;
	ffha_pkg::out_t res;
	logic           mem_we;
	logic [IW-1:0]  mem_waddr, mem_raddr;
	logic [EW-1:0]  mem_wdata, mem_rdata;
	logic           out_valid_q;
	ffha_pkg::out_t out_data_q;
	logic           out_fail;

	ffha_engine #(
		.ARENA_BYTES (ARENA_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid && in_ready),
		.cmd_in   (in_data),
		.idle     (eng_idle),
		.res_valid(res_valid),
		.res      (res),
		.res_ack  (res_ack),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ffha_seg_mem #(
		.WIDTH(EW),
		.DEPTH(MAX_SEGMENTS)
	) u_seg_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_ready = eng_idle;
	assign res_ack  = res_valid && (!out_valid_q || out_ready);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_fail  = out_valid && (out_data.status != ffha_pkg::ST_OK);

	// A failed or free result carries no offset and no split mark.
	`CHK_SAME(a_fail_no_offset, out_fail, (out_data.payload_offset == 14'd0) && !out_data.was_split)
	// A split is only reported with a successful grant.
	`CHK_SAME(a_split_ok, out_valid && out_data.was_split, out_data.status == ffha_pkg::ST_OK)
	// One transaction at a time: no second accept right after one.
	`CHK_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

// File: bench/first_fit_heap_allocator_tb.sv
// Self-checking testbench of the first-fit heap allocator.
// Depends on ffha_pkg and first_fit_heap_allocator; a local segment table predicts each result.
module first_fit_heap_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ARENA    = ffha_pkg::ARENA_BYTES_DEF;
	localparam int HDR      = ffha_pkg::HEADER_BYTES_DEF;
	localparam int MAXSEG   = ffha_pkg::MAX_SEGMENTS_DEF;
	localparam int N_RANDOM = 420;
	localparam int IDLE_PCT = 31;
	localparam int WD_LIMIT = 20000;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	ffha_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	ffha_pkg::out_t out_data;

	first_fit_heap_allocator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Predicted segment table.
	int unsigned tbl_start[MAXSEG];
	int unsigned tbl_size[MAXSEG];
	bit          tbl_busy[MAXSEG];
	int unsigned tbl_count;

	ffha_pkg::out_t pending_results[$];
	int unsigned    errors;
	bit             free_idle;
	bit             hold_receiver;

	// Granted payload offsets, used to build valid free requests.
	int unsigned live_offsets[$];

	initial begin
		clk = 1'b0;
	end
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
	endtask

	function automatic void heap_reset();
		tbl_start[0] = 0;
		tbl_size[0]  = ARENA - HDR;
		tbl_busy[0]  = 1'b0;
		tbl_count    = 1;
	endfunction

	// Remove one table entry, shifting the ones above down.
	function automatic void heap_drop(input int unsigned idx);
		for (int unsigned k = idx; k + 1 < tbl_count; k++) begin
			tbl_start[k] = tbl_start[k + 1];
			tbl_size[k]  = tbl_size[k + 1];
			tbl_busy[k]  = tbl_busy[k + 1];
		end
		tbl_count--;
	endfunction

	// Compute the result of one request and update the table.
	function automatic ffha_pkg::out_t heap_apply(input ffha_pkg::in_t req);
		ffha_pkg::out_t res;
		int unsigned    i;
		int unsigned    want;
		int unsigned    off;
		res = '{status: ffha_pkg::ST_NOFIT, payload_offset: '0, was_split: 1'b0};
		want = 32'(req.req_bytes);
		off = 32'(req.release_offset);
		if (req.command == ffha_pkg::CMD_ALLOC) begin
			for (i = 0; i < tbl_count; i++)
				if (!tbl_busy[i] && tbl_size[i] >= want) break;
			if (i < tbl_count) begin
				if (tbl_size[i] == want) begin
					tbl_busy[i] = 1'b1;
					res.status = ffha_pkg::ST_OK;
					res.payload_offset = 14'(tbl_start[i] + HDR);
				end else if (tbl_size[i] > want + HDR) begin
					if (tbl_count >= MAXSEG) begin
						res.status = ffha_pkg::ST_FULL;
					end else begin
						for (int unsigned k = tbl_count; k > i + 1; k--) begin
							tbl_start[k] = tbl_start[k - 1];
							tbl_size[k]  = tbl_size[k - 1];
							tbl_busy[k]  = tbl_busy[k - 1];
						end
						tbl_start[i + 1] = tbl_start[i] + HDR + want;
						tbl_size[i + 1]  = tbl_size[i] - want - HDR;
						tbl_busy[i + 1]  = 1'b0;
						tbl_size[i]      = want;
						tbl_busy[i]      = 1'b1;
						tbl_count++;
						res.status = ffha_pkg::ST_OK;
						res.payload_offset = 14'(tbl_start[i] + HDR);
						res.was_split = 1'b1;
					end
				end
			end
			if (res.status == ffha_pkg::ST_OK) live_offsets.push_back(32'(res.payload_offset));
		end else begin
			for (i = 0; i < tbl_count; i++)
				if (tbl_start[i] + HDR == off) break;
			if (i >= tbl_count || !tbl_busy[i]) begin
				res.status = ffha_pkg::ST_BADPTR;
			end else begin
				tbl_busy[i] = 1'b0;
				i = 0;
				// Merge adjacent free segments until none are left.
				while (i + 1 < tbl_count) begin
					if (!tbl_busy[i] && !tbl_busy[i + 1]) begin
						tbl_size[i] += tbl_size[i + 1] + HDR;
						heap_drop(i + 1);
					end else begin
						i++;
					end
				end
				res.status = ffha_pkg::ST_OK;
				foreach (live_offsets[j])
					if (live_offsets[j] == off) begin
						live_offsets.delete(j);
						break;
					end
			end
		end
		return res;
	endfunction

	// Offer one transaction, wait until it is accepted, then drop valid.
	task automatic send_request(input ffha_pkg::in_t req, input bit idle_ok);
		while (idle_ok && !free_idle && $urandom_range(99) < IDLE_PCT) begin
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(heap_apply(req));
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic ffha_pkg::in_t make_req(input bit cmd, input int unsigned bytes,
		input int unsigned off);
		ffha_pkg::in_t r;
		r.command = cmd;
		r.req_bytes = 15'(bytes);
		r.release_offset = 14'(off);
		return r;
	endfunction

	// Random request: mostly plausible allocations and frees of live blocks.
	function automatic ffha_pkg::in_t random_req();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 45) begin
			if ($urandom_range(9) == 0)
				return make_req(ffha_pkg::CMD_ALLOC, $urandom_range(32767), 0);
			return make_req(ffha_pkg::CMD_ALLOC, $urandom_range(200), $urandom);
		end
		if (sel < 90 && live_offsets.size() > 0)
			return make_req(ffha_pkg::CMD_FREE, $urandom,
				live_offsets[$urandom_range(live_offsets.size() - 1)]);
		return make_req(ffha_pkg::CMD_FREE, $urandom, $urandom_range(16383));
	endfunction

	typedef struct {
		ffha_pkg::in_t  req;
		bit             known;
		ffha_pkg::out_t res;
	} dir_row_t;

	// Receiver: random stalls, plus one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !hold_receiver && (free_idle || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		ffha_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'(out_data), 0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.status !== want.status)
					report_mismatch("status", 32'(out_data.status), 32'(want.status));
				if (out_data.payload_offset !== want.payload_offset)
					report_mismatch("payload_offset", 32'(out_data.payload_offset),
						32'(want.payload_offset));
				if (out_data.was_split !== want.was_split)
					report_mismatch("was_split", 32'(out_data.was_split), 32'(want.was_split));
			end
		end
	end

	// Watchdog on cycles without any accepted transaction.
	initial begin
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
			if (quiet >= WD_LIMIT) begin
				$display("first_fit_heap_allocator test failed");
				$finish;
			end
		end
	end

	// Long receiver hold-off while the sender keeps going.
	initial begin
		hold_receiver = 1'b0;
		wait (arst_n);
		repeat (300) @(posedge clk);
		hold_receiver = 1'b1;
		repeat (2000) @(posedge clk);
		hold_receiver = 1'b0;
	end

	initial begin
		dir_row_t dir_rows[$];
		dir_row_t row;
		errors = 0;
		free_idle = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		heap_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows: extremes, exact fit, too-small split, bad pointers, zero size.
		dir_rows.push_back('{make_req(ffha_pkg::CMD_FREE, 0, HDR), 1'b1,
			'{ffha_pkg::ST_BADPTR, 14'd0, 1'b0}});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_ALLOC, 32767, 16383), 1'b1,
			'{ffha_pkg::ST_NOFIT, 14'd0, 1'b0}});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_ALLOC, 16384, 0), 1'b1,
			'{ffha_pkg::ST_NOFIT, 14'd0, 1'b0}});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_ALLOC, ARENA - HDR, 0), 1'b1,
			'{ffha_pkg::ST_OK, 14'(HDR), 1'b0}});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_ALLOC, 0, 0), 1'b1,
			'{ffha_pkg::ST_NOFIT, 14'd0, 1'b0}});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_FREE, 32767, HDR), 1'b1,
			'{ffha_pkg::ST_OK, 14'd0, 1'b0}});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_FREE, 0, HDR), 1'b1,
			'{ffha_pkg::ST_BADPTR, 14'd0, 1'b0}});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_ALLOC, ARENA - 2 * HDR, 0), 1'b1,
			'{ffha_pkg::ST_NOFIT, 14'd0, 1'b0}});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_ALLOC, 0, 0), 1'b1,
			'{ffha_pkg::ST_OK, 14'(HDR), 1'b1}});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_ALLOC, 100, 0), 1'b0, '0});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_ALLOC, 200, 0), 1'b0, '0});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_FREE, 0, 2 * HDR), 1'b0, '0});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_ALLOC, 100, 0), 1'b0, '0});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_FREE, 0, 16383), 1'b1,
			'{ffha_pkg::ST_BADPTR, 14'd0, 1'b0}});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_FREE, 0, 0), 1'b1,
			'{ffha_pkg::ST_BADPTR, 14'd0, 1'b0}});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_FREE, 0, HDR), 1'b0, '0});
		dir_rows.push_back('{make_req(ffha_pkg::CMD_FREE, 0, HDR), 1'b1,
			'{ffha_pkg::ST_BADPTR, 14'd0, 1'b0}});
		foreach (dir_rows[n]) begin
			row = dir_rows[n];
			send_request(row.req, 1'b1);
			if (row.known && pending_results[$] != row.res)
				report_mismatch("directed row prediction", n, n);
		end

		// Fill the table with zero-byte grants until it reports full.
		for (int n = 0; n < MAXSEG + 2; n++)
			send_request(make_req(ffha_pkg::CMD_ALLOC, 0, 0), 1'b1);
		// Sender pause until everything has drained, then release the table.
		wait (pending_results.size() == 0);
		while (live_offsets.size() > 0)
			send_request(make_req(ffha_pkg::CMD_FREE, 0, live_offsets[$]), 1'b1);

		// Random part, with a stretch without idling in the middle.
		for (int n = 0; n < N_RANDOM; n++) begin
			free_idle = (n >= 150 && n < 300);
			send_request(random_req(), 1'b1);
		end
		free_idle = 1'b0;

		// Drain and let the block settle.
		fork
			wait (pending_results.size() == 0);
			begin
				repeat (WD_LIMIT * 4) @(posedge clk);
			end
		join_any
		repeat (600) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("first_fit_heap_allocator test passed");
		end else begin
			$display("first_fit_heap_allocator test failed");
		end
		$finish;
	end

endmodule
